// File: hdl/logical_to_physical_channel_allocator_core_assert.svh
// Assertion macros shared by the channel allocator RTL.
`ifndef LOGICAL_TO_PHYSICAL_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH
`define LOGICAL_TO_PHYSICAL_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LTPCA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("channel allocator check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define LTPCA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("channel allocator check failed");

`endif

// File: hdl/ltpca_pkg.sv
// Types and constants for the logical-to-physical channel allocator.
package ltpca_pkg;

   localparam int LOGICAL_W  = 16;
   localparam int PHYS_W     = 6;

   typedef enum logic {
      OP_MAP   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 operation;
      logic [LOGICAL_W-1:0]   logical_channel;
   } req_type;

   typedef struct packed {
      logic [PHYS_W-1:0]      physical_channel;
      logic                   newly_assigned;
      logic                   all_slots_full;
   } rsp_type;

endpackage

// File: hdl/ltpca_rem.sv
// Remainder unit: dividend modulo a constant slot count by reciprocal multiply.
module ltpca_rem
   import ltpca_pkg::*;
#(
   parameter int DIVISOR = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [LOGICAL_W-1:0]          dividend,
   output logic                          done,
   output logic [$clog2(DIVISOR)-1:0]    remainder
);

   localparam int IDX_W       = $clog2(DIVISOR);
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = LOGICAL_W + RECIP_SHIFT;
   // floor(2^24 / DIVISOR): the quotient estimate is never high and at most one low
   localparam logic [RECIP_SHIFT-1:0] RECIP   = RECIP_SHIFT'((1 << RECIP_SHIFT) / DIVISOR);
   localparam logic [LOGICAL_W-1:0]   DIV_VAL = LOGICAL_W'(DIVISOR);

   logic [2:0]            stage_ff, stage_in;
   logic                  done_ff, done_in;
   logic [LOGICAL_W-1:0]  dividend_ff, dividend_in;
   logic [LOGICAL_W-1:0]  quot_ff, quot_in;
   logic [LOGICAL_W-1:0]  part_ff, part_in;
   logic [IDX_W-1:0]      rem_ff, rem_in;
   logic [PROD_W-1:0]     product;

   // Estimate the quotient, take the partial remainder, then correct it once
   always_comb begin
      product     = PROD_W'(dividend_ff) * PROD_W'(RECIP);
      stage_in    = {stage_ff[1:0], 1'b0};
      done_in     = done_ff;
      dividend_in = dividend_ff;
      quot_in     = product[PROD_W-1:RECIP_SHIFT];
      part_in     = dividend_ff - quot_ff * DIV_VAL;
      if (part_ff >= DIV_VAL) begin
         rem_in = IDX_W'(part_ff - DIV_VAL);
      end else begin
         rem_in = IDX_W'(part_ff);
      end
      if (start) begin
         stage_in    = 3'b001;
         done_in     = 1'b0;
         dividend_in = dividend;
      end else if (stage_ff[2]) begin
         done_in = 1'b1;
      end
   end

   // Hold the stage marks and finished flag; the data path needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      part_ff     <= part_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/logical_to_physical_channel_allocator_core.sv
// Top level of the channel allocator: sequencer, slot owner memory and used flags.
//
//   channel   ports                                direction   transfer marked by
//   request   start, busy, req_payload             in          start high, busy low
//   response  rsp_strobe, rsp_payload              out         rsp_strobe, one cycle
//
// A clear drops the used flags and shows its response in the cycle after the transfer.
// A map scans the owner memory for an existing mapping one slot a cycle through the
// single registered read port, then checks the preferred slot, then walks the used
// flags for the lowest free slot, reporting full if there is none. The preferred slot
// index is worked out during the lookup by a reciprocal-multiply remainder unit.
// Reset clears the used flags at once; there is no clearing pass. The response side
// cannot stall, so each response is shown for exactly one cycle.
`include "logical_to_physical_channel_allocator_core_assert.svh"

module logical_to_physical_channel_allocator_core
   import ltpca_pkg::*;
#(
   parameter int SLOT_COUNT = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_payload,
   output logic     busy,
   output logic     rsp_strobe,
   output rsp_type  rsp_payload
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_PREF,
      S_FREE
   } state_type;

   state_type               state_ff, state_in;
   logic [LOGICAL_W-1:0]    logical_ff, logical_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                    cmp_used_ff, cmp_used_in;
   logic [SLOT_COUNT-1:0]   used_ff, used_in;
   logic                    strobe_ff, strobe_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [LOGICAL_W-1:0]    rd_data_ff;

   logic [LOGICAL_W-1:0]    owner_mem [SLOT_COUNT];
   logic [IDX_W-1:0]        scan_idx;
   logic                    scan_live;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic                    rem_start;
   logic                    rem_done;
   logic [IDX_W-1:0]        rem_value;

   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_live = (scan_ff < CNT_W'(SLOT_COUNT));
   assign rd_addr   = scan_live ? scan_idx : '0;

   // Preferred slot: logical channel modulo the slot count
   ltpca_rem #(
      .DIVISOR   (SLOT_COUNT)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_payload.logical_channel),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // Owner memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[mem_waddr] <= logical_ff;
      end
      rd_data_ff <= owner_mem[rd_addr];
   end

   // Sequence lookup, preferred-slot check and free-slot walk
   always_comb begin
      state_in     = state_ff;
      logical_in   = logical_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      cmp_used_in  = cmp_used_ff;
      used_in      = used_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = scan_idx;
      rem_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_payload.operation == OP_CLEAR) begin
                  used_in   = '0;
                  strobe_in = 1'b1;
                  rsp_in    = '0;
               end else begin
                  logical_in = req_payload.logical_channel;
                  scan_in    = '0;
                  rem_start  = 1'b1;
                  state_in   = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            // issue the next read while comparing the previous one
            if (scan_live) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_idx;
               cmp_used_in  = used_ff[scan_idx];
               scan_in      = scan_ff + 1'b1;
            end
            if (cmp_valid_ff) begin
               if (cmp_used_ff && (rd_data_ff == logical_ff)) begin
                  strobe_in                   = 1'b1;
                  rsp_in.physical_channel     = PHYS_W'(cmp_idx_ff);
                  rsp_in.newly_assigned       = 1'b0;
                  rsp_in.all_slots_full       = 1'b0;
                  cmp_valid_in                = 1'b0;
                  state_in                    = S_IDLE;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  cmp_valid_in = 1'b0;
                  state_in     = S_PREF;
               end
            end
         end
         S_PREF: begin
            if (rem_done) begin
               if (!used_ff[rem_value]) begin
                  mem_we                  = 1'b1;
                  mem_waddr               = rem_value;
                  used_in[rem_value]      = 1'b1;
                  strobe_in               = 1'b1;
                  rsp_in.physical_channel = PHYS_W'(rem_value);
                  rsp_in.newly_assigned   = 1'b1;
                  rsp_in.all_slots_full   = 1'b0;
                  state_in                = S_IDLE;
               end else begin
                  scan_in  = '0;
                  state_in = S_FREE;
               end
            end
         end
         S_FREE: begin
            if (!scan_live) begin
               strobe_in = 1'b1;
               rsp_in    = '0;
               rsp_in.all_slots_full = 1'b1;
               state_in  = S_IDLE;
            end else if (!used_ff[scan_idx]) begin
               mem_we                  = 1'b1;
               used_in[scan_idx]       = 1'b1;
               strobe_in               = 1'b1;
               rsp_in.physical_channel = PHYS_W'(scan_idx);
               rsp_in.newly_assigned   = 1'b1;
               rsp_in.all_slots_full   = 1'b0;
               state_in                = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, used flags and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         used_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         used_ff      <= used_in;
         strobe_ff    <= strobe_in;
      end
      logical_ff  <= logical_in;
      cmp_idx_ff  <= cmp_idx_in;
      cmp_used_ff <= cmp_used_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   // Every accepted request leaves the block busy or answers on the next cycle
   `LTPCA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_strobe)
   // No response is shown while a map is still in progress
   `LTPCA_ASSERT_NOW(a_no_strobe_busy, busy, !rsp_strobe)
   // Full is reported only when every slot is taken
   `LTPCA_ASSERT_NOW(a_full_all_used, rsp_strobe && rsp_payload.all_slots_full, &used_ff)
   // A response never claims both a new mapping and a full store
   `LTPCA_ASSERT_NOW(a_fresh_not_full, rsp_strobe,
      !(rsp_payload.newly_assigned && rsp_payload.all_slots_full))

endmodule

// File: bench/ltpca_grant_checker.sv
// Checker for the channel allocator: predicts each slot grant and compares the responses.
module ltpca_grant_checker
   import ltpca_pkg::*;
#(
   parameter int SLOT_COUNT = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  req_type  req_payload,
   input  logic     rsp_strobe,
   input  rsp_type  rsp_payload,
   output int       grant_errors,
   output int       grants_owed
);

   // Shadow of the slot table
   logic [LOGICAL_W-1:0] owner_of [SLOT_COUNT];
   logic                 slot_taken [SLOT_COUNT];

   // Grants predicted at request time, oldest first
   rsp_type grants_due [$];
   int      error_tally = 0;

   initial begin
      grant_errors = 0;
      grants_owed  = 0;
   end

   // Mark a slot as owned by the channel and build its grant
   function automatic rsp_type claim_slot(int slot, logic [LOGICAL_W-1:0] channel);
      rsp_type grant = '0;
      slot_taken[slot] = 1'b1;
      owner_of[slot]   = channel;
      grant.physical_channel = PHYS_W'(slot);
      grant.newly_assigned   = 1'b1;
      return grant;
   endfunction

   // Apply one request to the shadow table and return the grant it should produce
   function automatic rsp_type predict_grant(req_type request);
      rsp_type grant = '0;
      int      preferred;
      if (request.operation == OP_CLEAR) begin
         for (int s = 0; s < SLOT_COUNT; s++) slot_taken[s] = 1'b0;
         return grant;
      end
      // return an existing mapping first
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (slot_taken[s] && owner_of[s] == request.logical_channel) begin
            grant.physical_channel = PHYS_W'(s);
            return grant;
         end
      end
      // try the preferred slot, then the lowest free one
      preferred = int'(request.logical_channel) % SLOT_COUNT;
      if (!slot_taken[preferred]) return claim_slot(preferred, request.logical_channel);
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (!slot_taken[s]) return claim_slot(s, request.logical_channel);
      end
      grant.all_slots_full = 1'b1;
      return grant;
   endfunction

   // Compare each response transfer, then record the grant for a new request transfer
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) slot_taken[s] = 1'b0;
         grants_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (grants_due.size() == 0) begin
               error_tally++;
               if (error_tally <= 10)
                  $display("[%0t] unexpected response: slot %0d new %b full %b", $realtime,
                           rsp_payload.physical_channel, rsp_payload.newly_assigned,
                           rsp_payload.all_slots_full);
            end else begin
               want = grants_due.pop_front();
               if (rsp_payload.physical_channel !== want.physical_channel ||
                   rsp_payload.newly_assigned !== want.newly_assigned ||
                   rsp_payload.all_slots_full !== want.all_slots_full) begin
                  error_tally++;
                  if (error_tally <= 10)
                     $display("[%0t] grant mismatch: slot %0d/%0d new %b/%b full %b/%b %s",
                              $realtime, want.physical_channel, rsp_payload.physical_channel,
                              want.newly_assigned, rsp_payload.newly_assigned,
                              want.all_slots_full, rsp_payload.all_slots_full,
                              "(expected/actual)");
               end
            end
         end
         if (start && !busy) grants_due.push_back(predict_grant(req_payload));
      end
      grant_errors <= error_tally;
      grants_owed  <= grants_due.size();
   end

endmodule

// File: bench/tb_logical_to_physical_channel_allocator_core.sv
// Testbench top for the channel allocator: clock, reset, request stimulus and verdict.
module tb_logical_to_physical_channel_allocator_core;
   import ltpca_pkg::*;

   localparam int SLOTS        = 64;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 4 * SLOTS + 20;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      grant_errors;
   int      grants_owed;
   int      cycle_count = 0;

   // Stimulus state: sender idling, channel pool for the current round, last mapped channel
   bit                   idle_on = 1'b1;
   logic [LOGICAL_W-1:0] channel_pool [96];
   int                   pool_size = 1;
   logic [LOGICAL_W-1:0] last_channel = '0;

   logical_to_physical_channel_allocator_core #(
      .SLOT_COUNT(SLOTS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   ltpca_grant_checker #(
      .SLOT_COUNT(SLOTS)
   ) u_grant_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload),
      .grant_errors (grant_errors),
      .grants_owed  (grants_owed)
   );

   always #6 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one request until it transfers, idling at random while idle_on is set
   task automatic send_request(op_type op, logic [LOGICAL_W-1:0] channel);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         if (idle_on && $urandom_range(99) < 33) begin
            start <= 1'b0;
         end else begin
            start       <= 1'b1;
            req_payload <= '{operation: op, logical_channel: channel};
         end
         @(posedge clock);
         taken = start && !busy;
      end
   endtask

   task automatic send_map(logic [LOGICAL_W-1:0] channel);
      send_request(OP_MAP, channel);
      last_channel = channel;
   endtask

   // Hold off requests until every grant has come back
   task automatic drain_grants();
      start <= 1'b0;
      do @(posedge clock); while (grants_owed != 0);
   endtask

   // Pick a channel: reuse from the pool, fresh values, preferred-slot collisions, repeats, extremes
   function automatic logic [LOGICAL_W-1:0] next_channel();
      int                   pick;
      logic [LOGICAL_W-1:0] channel;
      pick = $urandom_range(99);
      if (pick < 35) begin
         channel = channel_pool[$urandom_range(pool_size - 1)];
      end else if (pick < 55) begin
         channel = LOGICAL_W'($urandom);
      end else if (pick < 80) begin
         channel = {10'($urandom), last_channel[5:0]};
      end else if (pick < 90) begin
         channel = last_channel;
      end else begin
         case ($urandom_range(5))
            0:       channel = '0;
            1:       channel = '1;
            2:       channel = 16'd63;
            3:       channel = 16'd64;
            4:       channel = 16'h8000;
            default: channel = 16'h7FFF;
         endcase
      end
      return channel;
   endfunction

   initial begin
      int sent;
      int round_len;
      int round_no;
      sent     = 0;
      round_no = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: found, preferred, lowest free, clear with stale owners, bit patterns
      send_request(OP_CLEAR, 16'h0000);
      send_map(16'h0000);
      send_map(16'h0000);
      send_map(16'd64);
      send_map(16'hFFFF);
      send_map(16'd63);
      send_map(16'd64);
      send_request(OP_CLEAR, 16'hFFFF);
      send_map(16'hFFFF);
      send_map(16'h0000);
      send_map(16'h8000);
      send_map(16'h5555);
      send_map(16'hAAAA);
      send_request(OP_CLEAR, 16'h5555);
      drain_grants();

      // Random rounds: each starts from a clear; long rounds run the table full
      while (sent < RANDOM_ITEMS) begin
         round_len = (round_no == 0) ? 150 : $urandom_range(10, 160);
         pool_size = $urandom_range(4, 96);
         for (int i = 0; i < pool_size; i++) begin
            channel_pool[i] = LOGICAL_W'($urandom);
            if ($urandom_range(99) < 40) channel_pool[i][5:0] = 6'($urandom_range(3));
         end
         send_request(OP_CLEAR, LOGICAL_W'($urandom));
         sent++;
         for (int k = 0; k < round_len; k++) begin
            idle_on = !(sent >= 700 && sent < 1000);
            if ($urandom_range(199) == 0) send_request(OP_CLEAR, LOGICAL_W'($urandom));
            else send_map(next_channel());
            sent++;
         end
         if ($urandom_range(3) == 0) drain_grants();
         round_no++;
      end

      drain_grants();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grant_errors == 0 && grants_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
